FILE: hdl/mpsb_pkg.sv
`default_nettype none

package mpsb_pkg;

    localparam int unsigned PLANES_DEF        = 4;
    localparam int unsigned SCREEN_WIDTH_DEF  = 128;
    localparam int unsigned SCREEN_HEIGHT_DEF = 64;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned COORD_W    = 8;
    localparam int unsigned ROWS_W     = 4;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PLANE_W    = 2;
    localparam int unsigned RROW_W     = 6;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned S_DATA_W   = 40;
    localparam int unsigned M_DATA_W   = 80;

    localparam logic [CFG_ADDR_W-1:0] REG_PLANE_MASK = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BRUSH_MODE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_RES   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_BYTE  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        BRUSH_XOR   = 2'd0,
        BRUSH_CLEAR = 2'd1,
        BRUSH_SET   = 2'd2
    } brush_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD0,
        S_MOD1,
        S_RDCAP
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_BEGIN,
        CMD_SKIP,
        CMD_DRAW_RD,
        CMD_MOD0,
        CMD_MOD1,
        CMD_READ_RD,
        CMD_READ_CAP
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic draw_pending;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/mpsb_ctrl.sv
`default_nettype none

module mpsb_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mpsb_pkg::OP_W-1:0]       op,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  mpsb_pkg::dp_status_t            status,
    output mpsb_pkg::ctrl_cmd_t             cmd
);

    mpsb_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;
    logic             accept;

    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpsb_pkg::S_CLEAR: begin
                if (status.clr_last) begin
                    state_next = mpsb_pkg::S_IDLE;
                end
            end
            mpsb_pkg::S_IDLE: begin
                if (accept) begin
                    case (mpsb_pkg::op_t'(op))
                        mpsb_pkg::OP_BYTE: begin
                            if (status.draw_pending) begin
                                state_next = mpsb_pkg::S_MOD0;
                            end
                        end
                        mpsb_pkg::OP_READ: begin
                            state_next = mpsb_pkg::S_RDCAP;
                        end
                        default: ;
                    endcase
                end
            end
            mpsb_pkg::S_MOD0:  state_next = mpsb_pkg::S_MOD1;
            mpsb_pkg::S_MOD1:  state_next = mpsb_pkg::S_IDLE;
            mpsb_pkg::S_RDCAP: state_next = mpsb_pkg::S_IDLE;
            default:           state_next = mpsb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = (state_reg == mpsb_pkg::S_IDLE) && out_free;
        cmd.cmd      = mpsb_pkg::CMD_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            mpsb_pkg::S_CLEAR: begin
                cmd.cmd = mpsb_pkg::CMD_CLEAR;
            end
            mpsb_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (mpsb_pkg::op_t'(op))
                        mpsb_pkg::OP_BEGIN: begin
                            cmd.cmd      = mpsb_pkg::CMD_BEGIN;
                            cmd.out_load = 1'b1;
                        end
                        mpsb_pkg::OP_BYTE: begin
                            if (status.draw_pending) begin
                                cmd.cmd = mpsb_pkg::CMD_DRAW_RD;
                            end else begin
                                cmd.cmd      = mpsb_pkg::CMD_SKIP;
                                cmd.out_load = 1'b1;
                            end
                        end
                        mpsb_pkg::OP_READ: begin
                            cmd.cmd = mpsb_pkg::CMD_READ_RD;
                        end
                        default: begin
                            cmd.cmd      = mpsb_pkg::CMD_SKIP;
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            mpsb_pkg::S_MOD0: begin
                cmd.cmd = mpsb_pkg::CMD_MOD0;
            end
            mpsb_pkg::S_MOD1: begin
                cmd.cmd      = mpsb_pkg::CMD_MOD1;
                cmd.out_load = 1'b1;
            end
            mpsb_pkg::S_RDCAP: begin
                cmd.cmd      = mpsb_pkg::CMD_READ_CAP;
                cmd.out_load = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mpsb_pkg::S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mpsb_pkg::S_CLEAR) |-> !s_tready)
        else $error("transaction accepted during frame store clear");

    a_load_needs_free_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result register overwritten while still held");

    a_draw_result_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cmd == mpsb_pkg::CMD_DRAW_RD) |=> ##1 cmd.out_load)
        else $error("sprite byte result not produced after read-modify-write");

    a_read_result_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cmd == mpsb_pkg::CMD_READ_RD) |=> cmd.out_load)
        else $error("read result not produced one cycle after memory read");

endmodule

`default_nettype wire

FILE: hdl/mpsb_dp.sv
`default_nettype none

module mpsb_dp #(
    parameter int unsigned PLANES        = mpsb_pkg::PLANES_DEF,
    parameter int unsigned SCREEN_WIDTH  = mpsb_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = mpsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mpsb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mpsb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [mpsb_pkg::COORD_W-1:0]        x_pos,
    input  logic [mpsb_pkg::COORD_W-1:0]        y_pos,
    input  logic [mpsb_pkg::ROWS_W-1:0]         rows,
    input  logic [mpsb_pkg::BYTE_W-1:0]         sprite_byte,
    input  logic [mpsb_pkg::PLANE_W-1:0]        read_plane,
    input  logic [mpsb_pkg::RROW_W-1:0]         read_row,
    input  logic                                read_half,
    input  mpsb_pkg::ctrl_cmd_t                 cmd,
    output mpsb_pkg::dp_status_t                status,
    output logic [mpsb_pkg::COUNT_W-1:0]        bytes_needed,
    output logic                                collision,
    output logic                                last,
    output logic [mpsb_pkg::WORD_W-1:0]         pixel_word
);

    localparam int unsigned DEPTH     = PLANES * SCREEN_HEIGHT * 2;
    localparam int unsigned AW        = $clog2(DEPTH);
    localparam int unsigned XW        = $clog2(SCREEN_WIDTH);
    localparam int unsigned YW        = $clog2(SCREEN_HEIGHT);
    localparam int unsigned PLANE_WDS = SCREEN_HEIGHT * 2;
    localparam int unsigned WW        = mpsb_pkg::WORD_W;
    localparam int unsigned PW        = mpsb_pkg::PLANE_W;
    localparam int unsigned CW        = mpsb_pkg::COUNT_W;

    logic [WW-1:0] mem [DEPTH];
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [WW-1:0] mem_wdata;
    logic [WW-1:0] mem_rdata_reg;

    logic [3:0]    plane_mask_reg, plane_mask_next;
    logic [1:0]    brush_reg, brush_next;
    logic          wrap_reg, wrap_next;
    logic          high_res_reg, high_res_next;

    logic [XW-1:0] cursor_x_reg, cursor_x_next;
    logic [YW-1:0] cursor_y_reg, cursor_y_next;
    logic [YW-1:0] origin_y_reg, origin_y_next;
    logic [4:0]    row_counter_reg, row_counter_next;
    logic [4:0]    plane_rows_reg, plane_rows_next;
    logic [PW-1:0] plane_cursor_reg, plane_cursor_next;
    logic          second_half_reg, second_half_next;
    logic          wide_reg, wide_next;
    logic [CW-1:0] bytes_left_reg, bytes_left_next;
    logic          coll_reg, coll_next;
    logic [7:0]    data_reg, data_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [CW-1:0] out_bytes_reg, out_bytes_val;
    logic          out_coll_reg, out_coll_val;
    logic          out_last_reg, out_last_val;
    logic [WW-1:0] out_pix_reg, out_pix_val;

    logic [7:0]        wmask;
    logic [YW-1:0]     hmask;
    logic [6:0]        scr_h;
    logic [PLANES-1:0] live;
    logic [YW-1:0]     origin_calc;
    logic [6:0]        room;
    logic [4:0]        n_rows;
    logic [4:0]        prows_calc;
    logic [2:0]        plane_cnt;
    logic [7:0]        prod;
    logic [CW-1:0]     bytes_calc;
    logic [PW-1:0]     first_plane;
    logic [PW-1:0]     next_plane;

    logic [YW-1:0]     y_draw;
    logic [YW-1:0]     y_plus;
    logic [7:0]        x0;
    logic [7:0]        xs;
    logic              in_scr;
    logic [WW-1:0]     mask0;
    logic [WW-1:0]     mask1;
    logic [AW-1:0]     addr_h0;
    logic [AW-1:0]     addr_h1;
    logic              rd_in_range;
    logic [AW-1:0]     rd_addr;
    logic [WW-1:0]     new0;
    logic [WW-1:0]     new1;
    logic              hit0;
    logic              hit1;
    logic [4:0]        rc_inc;

    function automatic logic [WW-1:0] brush_apply(input logic [WW-1:0] w,
                                                  input logic [WW-1:0] m,
                                                  input logic [1:0]    mode);
        logic [WW-1:0] r;
        case (mpsb_pkg::brush_t'(mode))
            mpsb_pkg::BRUSH_XOR:   r = w ^ m;
            mpsb_pkg::BRUSH_CLEAR: r = w & ~m;
            mpsb_pkg::BRUSH_SET:   r = w | m;
            default:               r = w;
        endcase
        return r;
    endfunction

    // screen geometry
    always_comb begin
        wmask = high_res_reg ? 8'(SCREEN_WIDTH - 1) : 8'(SCREEN_WIDTH / 2 - 1);
        hmask = high_res_reg ? YW'(SCREEN_HEIGHT - 1) : YW'(SCREEN_HEIGHT / 2 - 1);
        scr_h = high_res_reg ? 7'(SCREEN_HEIGHT) : 7'(SCREEN_HEIGHT / 2);
        live  = plane_mask_reg[PLANES-1:0];
    end

    // begin setup
    always_comb begin
        origin_calc = YW'(y_pos) & hmask;
        room        = scr_h - 7'(origin_calc);
        n_rows      = (rows == '0) ? 5'd16 : {1'b0, rows};
        prows_calc  = (!wrap_reg && (7'(n_rows) > room)) ? 5'(room) : n_rows;
        plane_cnt   = 3'($countones(live));
        prod        = 8'(plane_cnt) * 8'(prows_calc);
        bytes_calc  = (rows == '0) ? CW'(prod << 1) : CW'(prod);
        first_plane = '0;
        for (int p = int'(PLANES) - 1; p >= 0; p--) begin
            if (live[p]) begin
                first_plane = PW'(p);
            end
        end
        next_plane = plane_cursor_reg;
        for (int q = int'(PLANES) - 1; q >= 0; q--) begin
            if (live[q] && (q > int'(plane_cursor_reg))) begin
                next_plane = PW'(q);
            end
        end
    end

    // pixel masks for the current byte over both row words
    always_comb begin
        y_draw = cursor_y_reg & hmask;
        y_plus = (y_draw + YW'(1)) & hmask;
        x0     = 8'(cursor_x_reg) + (second_half_reg ? 8'd8 : 8'd0);
        xs     = wrap_reg ? (x0 & wmask) : x0;
        in_scr = wrap_reg || (x0 <= wmask);
        mask0  = '0;
        mask1  = '0;
        for (int b = 0; b < 8; b++) begin
            logic [7:0] pb;
            logic [7:0] col;
            pb  = xs + 8'(b);
            col = wrap_reg ? (pb & wmask) : pb;
            if (in_scr && data_reg[3'(7 - b)] && (wrap_reg || (pb <= wmask))) begin
                if (col[6]) begin
                    mask1[col[5:0]] = 1'b1;
                end else begin
                    mask0[col[5:0]] = 1'b1;
                end
            end
        end
        addr_h0 = AW'(32'(plane_cursor_reg) * PLANE_WDS + 32'(y_draw) * 32'd2);
        addr_h1 = AW'(32'(plane_cursor_reg) * PLANE_WDS + 32'(y_draw) * 32'd2 + 32'd1);
        new0    = brush_apply(mem_rdata_reg, mask0, brush_reg);
        new1    = brush_apply(mem_rdata_reg, mask1, brush_reg);
        hit0    = |(mem_rdata_reg & mask0);
        hit1    = |(mem_rdata_reg & mask1);
        rc_inc  = row_counter_reg + 5'd1;
        rd_in_range = (32'(read_plane) < PLANES) && (32'(read_row) < SCREEN_HEIGHT);
        rd_addr = AW'(32'(read_plane) * PLANE_WDS + 32'(read_row) * 32'd2
                      + 32'(read_half));
    end

    always_comb begin
        plane_mask_next   = plane_mask_reg;
        brush_next        = brush_reg;
        wrap_next         = wrap_reg;
        high_res_next     = high_res_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        origin_y_next     = origin_y_reg;
        row_counter_next  = row_counter_reg;
        plane_rows_next   = plane_rows_reg;
        plane_cursor_next = plane_cursor_reg;
        second_half_next  = second_half_reg;
        wide_next         = wide_reg;
        bytes_left_next   = bytes_left_reg;
        coll_next         = coll_reg;
        data_next         = data_reg;
        rd_ok_next        = rd_ok_reg;
        clr_cnt_next      = clr_cnt_reg;
        out_bytes_val     = '0;
        out_coll_val      = 1'b0;
        out_last_val      = 1'b0;
        out_pix_val       = '0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = addr_h0;
        mem_raddr         = addr_h0;
        mem_wdata         = '0;

        if (cfg_we) begin
            case (cfg_addr)
                mpsb_pkg::REG_PLANE_MASK: plane_mask_next = cfg_wdata[3:0];
                mpsb_pkg::REG_BRUSH_MODE: brush_next      = cfg_wdata[1:0];
                mpsb_pkg::REG_WRAP:       wrap_next       = cfg_wdata[0];
                mpsb_pkg::REG_HIGH_RES:   high_res_next   = cfg_wdata[0];
                default: ;
            endcase
        end

        case (cmd.cmd)
            mpsb_pkg::CMD_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            mpsb_pkg::CMD_BEGIN: begin
                coll_next         = 1'b0;
                cursor_x_next     = XW'(x_pos & wmask);
                origin_y_next     = origin_calc;
                cursor_y_next     = origin_calc;
                wide_next         = (rows == '0);
                plane_rows_next   = prows_calc;
                row_counter_next  = '0;
                second_half_next  = 1'b0;
                plane_cursor_next = first_plane;
                bytes_left_next   = bytes_calc;
                out_bytes_val     = bytes_calc;
                out_last_val      = (bytes_calc == '0);
            end
            mpsb_pkg::CMD_DRAW_RD: begin
                mem_re    = 1'b1;
                mem_raddr = addr_h0;
                data_next = sprite_byte;
            end
            mpsb_pkg::CMD_MOD0: begin
                mem_we    = 1'b1;
                mem_waddr = addr_h0;
                mem_wdata = new0;
                mem_re    = 1'b1;
                mem_raddr = addr_h1;
                coll_next = coll_reg | hit0;
            end
            mpsb_pkg::CMD_MOD1: begin
                mem_we    = 1'b1;
                mem_waddr = addr_h1;
                mem_wdata = new1;
                coll_next = coll_reg | hit1;
                if (wide_reg && !second_half_reg) begin
                    second_half_next = 1'b1;
                end else begin
                    second_half_next = 1'b0;
                    if (rc_inc >= plane_rows_reg) begin
                        row_counter_next  = '0;
                        cursor_y_next     = origin_y_reg;
                        plane_cursor_next = next_plane;
                    end else begin
                        row_counter_next = rc_inc;
                        cursor_y_next    = y_plus;
                    end
                end
                bytes_left_next = bytes_left_reg - CW'(1);
                out_coll_val    = coll_reg | hit1;
                out_last_val    = (bytes_left_reg == CW'(1));
            end
            mpsb_pkg::CMD_READ_RD: begin
                mem_re     = rd_in_range;
                mem_raddr  = rd_addr;
                rd_ok_next = rd_in_range;
            end
            mpsb_pkg::CMD_READ_CAP: begin
                out_pix_val = rd_ok_reg ? mem_rdata_reg : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_mask_reg   <= 4'h1;
            brush_reg        <= mpsb_pkg::BRUSH_XOR;
            wrap_reg         <= 1'b0;
            high_res_reg     <= 1'b0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            origin_y_reg     <= '0;
            row_counter_reg  <= '0;
            plane_rows_reg   <= '0;
            plane_cursor_reg <= '0;
            second_half_reg  <= 1'b0;
            wide_reg         <= 1'b0;
            bytes_left_reg   <= '0;
            coll_reg         <= 1'b0;
            rd_ok_reg        <= 1'b0;
            clr_cnt_reg      <= '0;
        end else begin
            plane_mask_reg   <= plane_mask_next;
            brush_reg        <= brush_next;
            wrap_reg         <= wrap_next;
            high_res_reg     <= high_res_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            origin_y_reg     <= origin_y_next;
            row_counter_reg  <= row_counter_next;
            plane_rows_reg   <= plane_rows_next;
            plane_cursor_reg <= plane_cursor_next;
            second_half_reg  <= second_half_next;
            wide_reg         <= wide_next;
            bytes_left_reg   <= bytes_left_next;
            coll_reg         <= coll_next;
            rd_ok_reg        <= rd_ok_next;
            clr_cnt_reg      <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (cmd.out_load) begin
            out_bytes_reg <= out_bytes_val;
            out_coll_reg  <= out_coll_val;
            out_last_reg  <= out_last_val;
            out_pix_reg   <= out_pix_val;
        end
    end

    assign status.clr_last     = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.draw_pending = (bytes_left_reg != '0);

    assign bytes_needed = out_bytes_reg;
    assign collision    = out_coll_reg;
    assign last         = out_last_reg;
    assign pixel_word   = out_pix_reg;

endmodule

`default_nettype wire

FILE: hdl/multiplane_sprite_blitter_top.sv
// Multi-plane sprite blitter over a one-bit-per-pixel frame store of PLANES planes,
// each SCREEN_HEIGHT rows of two 64-bit words. After reset the store is cleared one
// word per cycle, PLANES*SCREEN_HEIGHT*2 words (512 at the defaults), and no input
// transaction is taken until that pass ends; configuration writes are taken at any
// time but should only be issued while the block is idle. Every input transaction
// gives exactly one result transaction. A begin reports the number of sprite bytes
// the draw consumes. While a draw is pending, a sprite byte is applied as a
// read-modify-write of both words of the target row, one word per cycle, as the
// frame store has one read and one write port. A read passes through the registered
// memory read. Result transactions are held in an output register, and the next
// input is taken in the cycle that register frees.
`default_nettype none

module multiplane_sprite_blitter_top #(
    parameter int unsigned PLANES        = mpsb_pkg::PLANES_DEF,
    parameter int unsigned SCREEN_WIDTH  = mpsb_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = mpsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mpsb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [mpsb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // x_pos[7:0], y_pos[15:8], rows[19:16], sprite_byte[27:20], read_plane[29:28],
    // read_row[35:30], read_half[36], zero[39:37]
    input  logic [mpsb_pkg::S_DATA_W-1:0]       s_tdata,
    // op[1:0]
    input  logic [mpsb_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bytes_needed[7:0], collision[8], pixel_word[72:9], zero[79:73]
    output logic [mpsb_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    mpsb_pkg::ctrl_cmd_t               cmd;
    mpsb_pkg::dp_status_t              status;
    logic [mpsb_pkg::COUNT_W-1:0]      bytes_needed;
    logic                              collision;
    logic [mpsb_pkg::WORD_W-1:0]       pixel_word;

    mpsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mpsb_dp #(
        .PLANES        (PLANES),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .x_pos        (s_tdata[7:0]),
        .y_pos        (s_tdata[15:8]),
        .rows         (s_tdata[19:16]),
        .sprite_byte  (s_tdata[27:20]),
        .read_plane   (s_tdata[29:28]),
        .read_row     (s_tdata[35:30]),
        .read_half    (s_tdata[36]),
        .cmd          (cmd),
        .status       (status),
        .bytes_needed (bytes_needed),
        .collision    (collision),
        .last         (m_tlast),
        .pixel_word   (pixel_word)
    );

    assign m_tdata = {7'd0, pixel_word, collision, bytes_needed};

endmodule

`default_nettype wire
